// ----- hw/rtl/bdq_pkg.sv -----
// Shared constants, codes and value helpers for the bounded deque.
// No dependencies; every other file but bdq_ram refers to this package by scoped names.
package bdq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int CAP_W = 5;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int PADDR_W = 3;

  localparam logic [PTR_W-1:0] HEAD_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                   we;
    logic [PTR_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [PTR_W-1:0]       raddr;
  } ram_req_t;

  function automatic logic [VALUE_WIDTH-1:0] to_slot(input logic [DATA_W-1:0] d);
    logic [63:0] z;
    z = 64'(d);
    return z[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'($signed(v));
    return w[DATA_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/bdq_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bdq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// Deque control: head pointer, entry count, RAM addressing and result register.
// Depends on bdq_pkg; drives the slot RAM through a bdq_pkg::ram_req_t.
module bdq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bdq_pkg::CAP_W-1:0]    capacity,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bdq_pkg::DATA_W-1:0]   s_tdata,
  input  logic [bdq_pkg::CMD_W-1:0]    s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bdq_pkg::DATA_W-1:0]   m_tdata,
  output logic [bdq_pkg::STAT_W:0]     m_tuser,
  output bdq_pkg::ram_req_t            ram_req,
  input  logic [bdq_pkg::VALUE_WIDTH-1:0] rd_data
);

  logic [bdq_pkg::PTR_W-1:0] head, head_next;
  logic [bdq_pkg::CNT_W-1:0] count, count_next;
  logic                      pend;
  logic                      pend_right;

  logic                      accept;
  logic                      is_push;
  logic                      right;
  logic [bdq_pkg::LIM_W-1:0] cap_ext;
  logic [bdq_pkg::LIM_W-1:0] limit;
  logic                      full;
  logic                      empty;
  logic [bdq_pkg::SUM_W-1:0] sum;
  logic [bdq_pkg::SUM_W-1:0] sum_m1;
  logic [bdq_pkg::PTR_W-1:0] tail_free;
  logic [bdq_pkg::PTR_W-1:0] tail_last;
  logic [bdq_pkg::PTR_W-1:0] head_dec;
  logic [bdq_pkg::PTR_W-1:0] head_inc;
  logic [bdq_pkg::VALUE_WIDTH-1:0] slot_in;

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_push  = !s_tuser[1];
  assign right    = s_tuser[0];

  assign cap_ext = bdq_pkg::LIM_W'(capacity);
  assign limit   = (cap_ext > bdq_pkg::LIM_W'(bdq_pkg::DEPTH)) ?
                   bdq_pkg::LIM_W'(bdq_pkg::DEPTH) : cap_ext;
  assign full    = bdq_pkg::LIM_W'(count) >= limit;
  assign empty   = (count == '0);

  assign sum       = bdq_pkg::SUM_W'(head) + bdq_pkg::SUM_W'(count);
  assign sum_m1    = sum - bdq_pkg::SUM_W'(1);
  assign tail_free = (sum >= bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) ?
                     bdq_pkg::PTR_W'(sum - bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) :
                     bdq_pkg::PTR_W'(sum);
  assign tail_last = (sum_m1 >= bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) ?
                     bdq_pkg::PTR_W'(sum_m1 - bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) :
                     bdq_pkg::PTR_W'(sum_m1);
  assign head_dec  = (head == '0) ? bdq_pkg::HEAD_LAST : head - bdq_pkg::PTR_W'(1);
  assign head_inc  = (head == bdq_pkg::HEAD_LAST) ? '0 : head + bdq_pkg::PTR_W'(1);
  assign slot_in   = bdq_pkg::to_slot(s_tdata);

  always_comb begin
    head_next     = head;
    count_next    = count;
    ram_req.we    = 1'b0;
    ram_req.waddr = right ? tail_free : head_dec;
    ram_req.wdata = slot_in;
    ram_req.re    = 1'b0;
    ram_req.raddr = right ? tail_last : head;
    if (accept) begin
      if (is_push && !full) begin
        ram_req.we = 1'b1;
        count_next = count + bdq_pkg::CNT_W'(1);
        if (!right) begin
          head_next = head_dec;
        end
      end else if (!is_push && !empty) begin
        ram_req.re = 1'b1;
        count_next = count - bdq_pkg::CNT_W'(1);
        if (!right) begin
          head_next = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // result register; a successful pop waits for the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else if (accept) begin
      if (is_push) begin
        m_tvalid <= 1'b1;
        m_tuser  <= {right, full ? bdq_pkg::ST_FULL : bdq_pkg::ST_PUSHED};
        m_tdata  <= full ? '0 : bdq_pkg::widen(slot_in);
      end else if (empty) begin
        m_tvalid <= 1'b1;
        m_tuser  <= {right, bdq_pkg::ST_EMPTY};
        m_tdata  <= '0;
      end else begin
        m_tvalid   <= 1'b0;
        pend       <= 1'b1;
        pend_right <= right;
      end
    end else if (pend) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b1;
      m_tuser  <= {pend_right, bdq_pkg::ST_POPPED};
      m_tdata  <= bdq_pkg::widen(rd_data);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/bounded_double_ended_queue.sv -----
// Bounded deque top level: capacity register on the APB port, control and slot RAM.
// A push or refused request is loaded into the result register at its transfer; a
// successful pop reads the slot RAM, then loads the result register, and takes
// no request meanwhile. Pushes and refusals: 1 per cycle while results are taken.
// Reset: synchronous; empties the queue, clears head, capacity returns to 16.
// Depends on bdq_pkg, bdq_ctrl and bdq_ram.
module bounded_double_ended_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bdq_pkg::DATA_W-1:0]    s_tdata,  // push_value
  input  logic [bdq_pkg::CMD_W-1:0]     s_tuser,  // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bdq_pkg::DATA_W-1:0]    m_tdata,  // result_value
  output logic [bdq_pkg::STAT_W:0]      m_tuser,  // status[1:0], from_right[2]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [bdq_pkg::CAP_W-1:0]       capacity;
  bdq_pkg::ram_req_t               ram_req;
  logic [bdq_pkg::VALUE_WIDTH-1:0] rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bdq_pkg::REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bdq_pkg::REG_CAPACITY) begin
      capacity <= pwdata[bdq_pkg::CAP_W-1:0];
    end
  end

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .ram_req  (ram_req),
    .rd_data  (rd_data)
  );

  bdq_ram #(
    .DEPTH_P (bdq_pkg::DEPTH),
    .WIDTH_P (bdq_pkg::VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

endmodule

// ----- hw/rtl/bdq_checker.sv -----
// Port-level checks for the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_double_ended_queue.
module bdq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [bdq_pkg::CMD_W-1:0]   s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [bdq_pkg::DATA_W-1:0]  m_tdata,
  input logic [bdq_pkg::STAT_W:0]    m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == bdq_pkg::ST_FULL || m_tuser[1:0] == bdq_pkg::ST_EMPTY)
    |-> m_tdata == '0)
    else $error("refused request carries data");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[1] |=> m_tvalid &&
    (m_tuser[1:0] == bdq_pkg::ST_PUSHED || m_tuser[1:0] == bdq_pkg::ST_FULL) &&
    m_tuser[2] == $past(s_tuser[0]))
    else $error("push transfer without matching result");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
